[sv/fud_pkg.sv]
// Shared types, codes and byte classification functions for the form token decoder.
`default_nettype none
package fud_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [7:0] MASK_LEAD2   = 8'hE0;
    localparam logic [7:0] MATCH_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3   = 8'hF0;
    localparam logic [7:0] MATCH_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4   = 8'hF8;
    localparam logic [7:0] MATCH_LEAD4  = 8'hF0;

    localparam logic [2:0] LEAD_PLAIN   = 3'd0;
    localparam logic [2:0] LEAD_BAD     = 3'd4;

    localparam logic [1:0] ENDING_EQUALS = 2'd0;
    localparam logic [1:0] ENDING_COMMA  = 2'd1;
    localparam logic [1:0] ENDING_INPUT  = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_LEAD  = 2'd1;
    localparam logic [1:0] ERR_NO_PCT    = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    typedef enum logic [5:0] {
        MODE_TEXT    = 6'b000001,
        MODE_HEX_HI  = 6'b000010,
        MODE_HEX_LO  = 6'b000100,
        MODE_CPCT    = 6'b001000,
        MODE_CHEX_HI = 6'b010000,
        MODE_CHEX_LO = 6'b100000
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [3:0] high_nibble;
        logic [1:0] cont_left;
        logic       seen_text;
        logic       discarding;
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic [1:0] ending;
        logic [1:0] error;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode:        MODE_TEXT,
        high_nibble: 4'd0,
        cont_left:   2'd0,
        seen_text:   1'b0,
        discarding:  1'b0
    };

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [2:0] lead_class(input logic [7:0] v);
        logic [2:0] cls;
        cls = LEAD_BAD;
        if (!v[7]) begin
            cls = LEAD_PLAIN;
        end else if ((v & MASK_LEAD2) == MATCH_LEAD2) begin
            cls = 3'd1;
        end else if ((v & MASK_LEAD3) == MATCH_LEAD3) begin
            cls = 3'd2;
        end else if ((v & MASK_LEAD4) == MATCH_LEAD4) begin
            cls = 3'd3;
        end
        return cls;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage
`default_nettype wire

[sv/form_urlencoded_token_decoder.sv]
// Top level of the form token decoder: parser state, result register and handshakes.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_in_byte, i_in_last
//   result   out        o_valid / i_stall  o_out_byte, o_byte_valid, o_token_end,
//                                          o_ending, o_error
//
// One byte is taken per cycle unless the input stalls; its result, if any, shows
// in the next cycle from the result register, set by one pass of the byte step logic.
// Reset is synchronous, active low, and returns the parser to text mode with no result.
// A new byte is taken while a result waits, as long as that result leaves this cycle.
// Input stalls only while a result is held and the output side stalls.
`default_nettype none
module form_urlencoded_token_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_token_end,
    output logic [1:0]      o_ending,
    output logic [1:0]      o_error
);
    import fud_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    n_emit;
    logic    accept;
    logic    taken;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign taken   = r_out_valid && !i_stall;

    fud_step u_step (
        .i_state (r_state),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .o_state (n_state),
        .o_emit  (n_emit),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_state     <= n_state;
            r_out_valid <= n_emit;
        end else if (taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_res.out_byte;
    assign o_byte_valid = r_res.byte_valid;
    assign o_token_end  = r_res.token_end;
    assign o_ending     = r_res.ending;
    assign o_error      = r_res.error;

endmodule
`default_nettype wire

[sv/fud_step.sv]
// Next-state and result logic for one encoded byte of the form token decoder.
`default_nettype none
module fud_step (
    input  wire fud_pkg::t_state i_state,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    output fud_pkg::t_state      o_state,
    output logic                 o_emit,
    output fud_pkg::t_result     o_res
);
    import fud_pkg::*;

    logic [7:0] v_hi;
    logic [7:0] v_cont;
    logic [2:0] cls;

    assign v_hi   = {i_state.high_nibble, hex_value(i_byte)};
    assign v_cont = v_hi;
    assign cls    = lead_class(v_hi);

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_res   = '0;

        if (i_state.discarding) begin
            if (i_last) begin
                o_state = STATE_RESET;
            end
        end else begin
            unique case (i_state.mode) inside
                MODE_HEX_HI, MODE_CHEX_HI: begin
                    o_state.high_nibble = hex_value(i_byte);
                    if (i_last) begin
                        o_emit        = 1'b1;
                        o_res.token_end = 1'b1;
                        o_res.ending  = ENDING_INPUT;
                        o_res.error   = ERR_TRUNCATED;
                        o_state       = STATE_RESET;
                    end else if (i_state.mode == MODE_HEX_HI) begin
                        o_state.mode = MODE_HEX_LO;
                    end else begin
                        o_state.mode = MODE_CHEX_LO;
                    end
                end
                MODE_HEX_LO: begin
                    o_emit = 1'b1;
                    if (cls == LEAD_BAD || (cls != LEAD_PLAIN && i_last)) begin
                        o_res.token_end = 1'b1;
                        o_res.ending    = ENDING_INPUT;
                        o_res.error     = (cls == LEAD_BAD) ? ERR_BAD_LEAD : ERR_TRUNCATED;
                        o_state            = STATE_RESET;
                        o_state.discarding = !i_last;
                    end else begin
                        o_res.out_byte   = v_hi;
                        o_res.byte_valid = 1'b1;
                        if (cls == LEAD_PLAIN) begin
                            o_state.mode = MODE_TEXT;
                            if (i_last) begin
                                o_res.token_end = 1'b1;
                                o_res.ending    = ENDING_INPUT;
                                o_state         = STATE_RESET;
                            end
                        end else begin
                            o_state.cont_left = cls[1:0];
                            o_state.mode      = MODE_CPCT;
                        end
                    end
                end
                MODE_CPCT: begin
                    if (i_byte != CHAR_PERCENT || i_last) begin
                        o_emit             = 1'b1;
                        o_res.token_end    = 1'b1;
                        o_res.ending       = ENDING_INPUT;
                        o_res.error        = (i_byte != CHAR_PERCENT) ? ERR_NO_PCT
                                                                      : ERR_TRUNCATED;
                        o_state            = STATE_RESET;
                        o_state.discarding = !i_last;
                    end else begin
                        o_state.mode = MODE_CHEX_HI;
                    end
                end
                MODE_CHEX_LO: begin
                    o_emit = 1'b1;
                    if (i_state.cont_left <= 2'd1) begin
                        o_res.out_byte    = v_cont;
                        o_res.byte_valid  = 1'b1;
                        o_state.cont_left = 2'd0;
                        o_state.mode      = MODE_TEXT;
                        if (i_last) begin
                            o_res.token_end = 1'b1;
                            o_res.ending    = ENDING_INPUT;
                            o_state         = STATE_RESET;
                        end
                    end else if (i_last) begin
                        o_res.token_end = 1'b1;
                        o_res.ending    = ENDING_INPUT;
                        o_res.error     = ERR_TRUNCATED;
                        o_state         = STATE_RESET;
                    end else begin
                        o_res.out_byte    = v_cont;
                        o_res.byte_valid  = 1'b1;
                        o_state.cont_left = i_state.cont_left - 2'd1;
                        o_state.mode      = MODE_CPCT;
                    end
                end
                default: begin
                    o_state.mode = MODE_TEXT;
                    if (i_byte == CHAR_EQUALS || i_byte == CHAR_COMMA) begin
                        o_emit            = 1'b1;
                        o_res.token_end   = 1'b1;
                        o_res.ending      = i_last ? ENDING_INPUT :
                                            (i_byte == CHAR_EQUALS) ? ENDING_EQUALS
                                                                    : ENDING_COMMA;
                        o_state.seen_text = 1'b0;
                        if (i_last) begin
                            o_state = STATE_RESET;
                        end
                    end else if (i_byte == CHAR_PERCENT) begin
                        o_state.seen_text = 1'b1;
                        if (i_last) begin
                            o_emit             = 1'b1;
                            o_res.token_end    = 1'b1;
                            o_res.ending       = ENDING_INPUT;
                            o_res.error        = ERR_TRUNCATED;
                            o_state            = STATE_RESET;
                        end else begin
                            o_state.mode = MODE_HEX_HI;
                        end
                    end else if (is_space(i_byte) && !i_state.seen_text) begin
                        if (i_last) begin
                            o_emit          = 1'b1;
                            o_res.token_end = 1'b1;
                            o_res.ending    = ENDING_INPUT;
                            o_state         = STATE_RESET;
                        end
                    end else begin
                        o_emit           = 1'b1;
                        o_res.byte_valid = 1'b1;
                        if (i_byte == CHAR_PLUS) begin
                            o_res.out_byte    = CHAR_SPACE;
                            o_state.seen_text = 1'b1;
                        end else begin
                            o_res.out_byte = i_byte;
                            if (!is_space(i_byte)) begin
                                o_state.seen_text = 1'b1;
                            end
                        end
                        if (i_last) begin
                            o_res.token_end = 1'b1;
                            o_res.ending    = ENDING_INPUT;
                            o_state         = STATE_RESET;
                        end
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/fud_checker.sv]
// Port-level checks for the form token decoder and their bind to the top level.
`default_nettype none
module fud_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_byte_valid,
    input wire logic       o_token_end,
    input wire logic [1:0] o_ending,
    input wire logic [1:0] o_error
);
    import fud_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_error))
        else $error("stalled request changed");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error != ERR_NONE |->
            o_token_end && !o_byte_valid && o_ending == ENDING_INPUT && o_out_byte == 8'd0)
        else $error("error request malformed");

    a_ending_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_token_end |-> o_ending == ENDING_EQUALS && o_byte_valid)
        else $error("mid-token request malformed");

endmodule

bind form_urlencoded_token_decoder fud_checker u_fud_checker (.*);
`default_nettype wire

[tb/fud_scoreboard_pkg.sv]
// Predictor and result checker for the form token decoder testbench.
package fud_scoreboard_pkg;
    import fud_pkg::*;

    class token_scoreboard;
        t_mode       mode;
        logic [3:0]  nibble_hi;
        logic [1:0]  owed;
        bit          in_token;
        bit          dropping;
        t_result     awaited[$];
        int unsigned errors;

        function new();
            reset_state();
            errors = 0;
        endfunction

        function void reset_state();
            mode      = MODE_TEXT;
            nibble_hi = '0;
            owed      = '0;
            in_token  = 0;
            dropping  = 0;
        endfunction

        function logic [3:0] digit_value(logic [7:0] c);
            logic [3:0] d;
            d = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = 4'(c - 8'h30);
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = 4'(c - 8'h37);
            end
            return d;
        endfunction

        // continuation escapes that follow a decoded byte, -1 for a bad lead
        function int owed_after(logic [7:0] v);
            casez (v)
                8'b0???????: return 0;
                8'b110?????: return 1;
                8'b1110????: return 2;
                8'b11110???: return 3;
                default:     return -1;
            endcase
        endfunction

        function bit blank(logic [7:0] c);
            return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function void queue_result(logic [7:0] b, bit v, bit e, logic [1:0] ending,
                                   logic [1:0] err);
            t_result r;
            r.out_byte   = v ? b : 8'h00;
            r.byte_valid = v;
            r.token_end  = e;
            r.ending     = e ? ending : '0;
            r.error      = err;
            awaited = {awaited, r};
            if (e && err == ERR_NONE) begin
                in_token = 0;
            end
        endfunction

        function void give_byte(logic [7:0] b, bit last);
            queue_result(b, 1, last, ENDING_INPUT, ERR_NONE);
            if (last) begin
                reset_state();
            end
        endfunction

        function void give_error(logic [1:0] code, bit last);
            queue_result(8'h00, 0, 1, ENDING_INPUT, code);
            reset_state();
            if (!last) begin
                dropping = 1;
            end
        endfunction

        // returns 0 when the request was dropped after an error
        function bit note_request(logic [7:0] b, bit last);
            logic [7:0] v;
            int         n;
            if (dropping) begin
                if (last) begin
                    reset_state();
                end
                return 0;
            end
            case (mode) inside
                MODE_HEX_HI, MODE_CHEX_HI: begin
                    nibble_hi = digit_value(b);
                    if (last) begin
                        give_error(ERR_TRUNCATED, 1);
                    end else if (mode == MODE_HEX_HI) begin
                        mode = MODE_HEX_LO;
                    end else begin
                        mode = MODE_CHEX_LO;
                    end
                end
                MODE_HEX_LO: begin
                    v = {nibble_hi, digit_value(b)};
                    n = owed_after(v);
                    if (n < 0) begin
                        give_error(ERR_BAD_LEAD, last);
                    end else if (n == 0) begin
                        mode = MODE_TEXT;
                        give_byte(v, last);
                    end else if (last) begin
                        give_error(ERR_TRUNCATED, 1);
                    end else begin
                        owed = 2'(n);
                        mode = MODE_CPCT;
                        give_byte(v, 0);
                    end
                end
                MODE_CPCT: begin
                    if (b != CHAR_PERCENT) begin
                        give_error(ERR_NO_PCT, last);
                    end else if (last) begin
                        give_error(ERR_TRUNCATED, 1);
                    end else begin
                        mode = MODE_CHEX_HI;
                    end
                end
                MODE_CHEX_LO: begin
                    v = {nibble_hi, digit_value(b)};
                    if (owed <= 2'd1) begin
                        owed = '0;
                        mode = MODE_TEXT;
                        give_byte(v, last);
                    end else if (last) begin
                        give_error(ERR_TRUNCATED, 1);
                    end else begin
                        owed = owed - 2'd1;
                        mode = MODE_CPCT;
                        give_byte(v, 0);
                    end
                end
                default: begin
                    mode = MODE_TEXT;
                    if (b == CHAR_EQUALS || b == CHAR_COMMA) begin
                        queue_result(8'h00, 0, 1, last ? ENDING_INPUT :
                                     (b == CHAR_EQUALS ? ENDING_EQUALS : ENDING_COMMA),
                                     ERR_NONE);
                        if (last) begin
                            reset_state();
                        end
                    end else if (b == CHAR_PLUS) begin
                        in_token = 1;
                        give_byte(CHAR_SPACE, last);
                    end else if (b == CHAR_PERCENT) begin
                        in_token = 1;
                        if (last) begin
                            give_error(ERR_TRUNCATED, 1);
                        end else begin
                            mode = MODE_HEX_HI;
                        end
                    end else if (blank(b) && !in_token) begin
                        if (last) begin
                            queue_result(8'h00, 0, 1, ENDING_INPUT, ERR_NONE);
                            reset_state();
                        end
                    end else begin
                        if (!blank(b)) begin
                            in_token = 1;
                        end
                        give_byte(b, last);
                    end
                end
            endcase
            return 1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: out_byte %02h token_end %0b error %0d",
                       got.out_byte, got.token_end, got.error);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid !== want.byte_valid) begin
                $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.token_end !== want.token_end) begin
                $error("token_end: expected %0b, got %0b", want.token_end, got.token_end);
                errors++;
            end
            if (got.ending !== want.ending) begin
                $error("ending: expected %0d, got %0d", want.ending, got.ending);
                errors++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0d, got %0d", want.error, got.error);
                errors++;
            end
        endfunction
    endclass

endpackage

[tb/form_urlencoded_token_decoder_test.sv]
// Testbench top for the form token decoder: stimulus, output handshake and final verdict.
module form_urlencoded_token_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fud_pkg::*;
    import fud_scoreboard_pkg::*;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_token_end;
    logic [1:0] o_ending;
    logic [1:0] o_error;

    token_scoreboard tokens;
    logic [7:0]      encoded[$];
    int unsigned     requests_sent = 0;
    int unsigned     results_seen  = 0;

    form_urlencoded_token_decoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_token_end  (o_token_end),
        .o_ending     (o_ending),
        .o_error      (o_error)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void add_char(logic [7:0] c);
        encoded = {encoded, c};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if ($urandom_range(24) == 0) begin
            return 8'($urandom_range(8'h61, 8'h7A));
        end
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    function automatic void add_escape(logic [7:0] v);
        add_char(CHAR_PERCENT);
        add_char(hex_char(v[7:4]));
        add_char(hex_char(v[3:0]));
    endfunction

    function automatic logic [7:0] lead_for(int n);
        return (n == 1) ? {3'b110, 5'($urandom)} :
               (n == 2) ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)};
    endfunction

    function automatic void add_blank();
        int k;
        k = $urandom_range(5);
        add_char((k == 5) ? CHAR_SPACE : 8'(8'h09 + k));
    endfunction

    function automatic void add_element();
        logic [7:0] c;
        int         n;
        case ($urandom_range(9)) inside
            [0:3]: begin
                do begin
                    c = ($urandom_range(7) == 0) ? 8'($urandom_range(128, 255))
                                                 : 8'($urandom_range(8'h21, 8'h7E));
                end while (c == CHAR_PERCENT || c == CHAR_PLUS || c == CHAR_EQUALS ||
                           c == CHAR_COMMA);
                add_char(c);
            end
            4: add_char(CHAR_PLUS);
            5: add_blank();
            [6:7]: add_escape(8'($urandom_range(127)));
            default: begin
                n = $urandom_range(1, 3);
                add_escape(lead_for(n));
                repeat (n) add_escape(8'($urandom));
            end
        endcase
    endfunction

    function automatic void add_token();
        repeat ($urandom_range(2)) add_blank();
        repeat ($urandom_range(5)) add_element();
    endfunction

    function automatic void add_delimiter();
        add_char($urandom_range(1) ? CHAR_EQUALS : CHAR_COMMA);
    endfunction

    function automatic void add_broken_tail();
        logic [7:0] c;
        int         n;
        case ($urandom_range(2))
            0: begin
                if ($urandom_range(1)) begin
                    add_char(CHAR_PERCENT);
                    if ($urandom_range(1)) add_char(hex_char(4'($urandom)));
                end else begin
                    n = $urandom_range(1, 3);
                    add_escape(lead_for(n));
                    repeat ($urandom_range(n - 1)) add_escape(8'($urandom));
                    case ($urandom_range(2))
                        1: add_char(CHAR_PERCENT);
                        2: begin
                            add_char(CHAR_PERCENT);
                            add_char(hex_char(4'($urandom)));
                        end
                        default: ;
                    endcase
                end
                return;
            end
            1: add_escape($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                            : 8'($urandom_range(8'hF8, 8'hFF)));
            default: begin
                n = $urandom_range(1, 3);
                add_escape(lead_for(n));
                repeat ($urandom_range(n - 1)) add_escape(8'($urandom));
                do c = 8'($urandom); while (c == CHAR_PERCENT);
                add_char(c);
            end
        endcase
        repeat ($urandom_range(4)) add_char(8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last);
        while (!(requests_sent >= 250 && requests_sent < 400) && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (o_stall);
        if (tokens.note_request(b, last)) requests_sent++;
    endtask

    task automatic send_text(input bit scatter_last);
        int n;
        n = encoded.size();
        if (n == 0) begin
            add_char("a");
            n = 1;
        end
        for (int i = 0; i < n; i++) begin
            send_byte(encoded[i], (i == n - 1) || (scatter_last && $urandom_range(15) == 0));
        end
        encoded.delete();
    endtask

    initial begin : sink
        int unsigned hold;
        t_result     got;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = '{o_out_byte, o_byte_valid, o_token_end, o_ending, o_error};
                tokens.check_result(got);
                results_seen++;
                if (results_seen == 60 || results_seen == 500) hold = 150;
            end
            // hold off long enough to back up the input side
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (results_seen >= 300 && results_seen < 420) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 6);
            end
        end
    end

    initial begin
        int unsigned waited;
        int          n;
        tokens = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        encoded = '{CHAR_SPACE, CHAR_PERCENT, "4", "1", CHAR_PLUS, CHAR_SPACE,
                    CHAR_COMMA, CHAR_EQUALS};
        send_text(0);
        encoded = '{CHAR_PERCENT, "E", "2", CHAR_PERCENT, "8", "2", "x", 8'hFF};
        send_text(0);
        encoded = '{CHAR_PERCENT, "F", "8"};
        send_text(0);
        encoded = '{CHAR_PERCENT, "4"};
        send_text(0);
        encoded = '{8'h09};
        send_text(0);
        encoded = '{8'h00};
        send_text(0);

        while (requests_sent < 620) begin
            case ($urandom_range(99)) inside
                [0:74]: begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) begin
                        add_token();
                        if (i < n - 1) add_delimiter();
                    end
                    if ($urandom_range(7) == 0) add_delimiter();
                    send_text(0);
                end
                [75:89]: begin
                    repeat ($urandom_range(2)) begin
                        add_token();
                        add_delimiter();
                    end
                    add_token();
                    add_broken_tail();
                    send_text(0);
                end
                default: begin
                    repeat ($urandom_range(1, 12)) add_char(8'($urandom));
                    send_text(1);
                end
            endcase
        end
        i_valid <= 1'b0;

        waited = 0;
        while (tokens.awaited.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (tokens.awaited.size() != 0) begin
            $error("%0d expected results never arrived", tokens.awaited.size());
            tokens.errors++;
        end
        if (tokens.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
sv/fud_pkg.sv
sv/fud_step.sv
sv/form_urlencoded_token_decoder.sv
sv/fud_checker.sv
tb/fud_scoreboard_pkg.sv
tb/form_urlencoded_token_decoder_test.sv
